@@ src/section_latency_monitor_macros.svh @@
// Assertion macros used by the checker of the latency monitor.
`ifndef SECTION_LATENCY_MONITOR_MACROS_SVH
`define SECTION_LATENCY_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/slm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

   localparam int SECTIONS           = 16;
   localparam int FRAMES_PER_SUMMARY = 64;
   localparam int SEC_AW             = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   localparam int TS_W       = 32;
   localparam int TOTAL_W    = 40;
   localparam int FRAC_W     = 8;
   localparam int FRAMES_W   = 11;
   localparam int SLOT_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [SLOT_W-1:0] FRAME_SLOT = 5'd16;

   // Event codes.
   localparam logic [1:0] OP_FRAME_BEGIN   = 2'd0;
   localparam logic [1:0] OP_FRAME_END     = 2'd1;
   localparam logic [1:0] OP_SECTION_BEGIN = 2'd2;
   localparam logic [1:0] OP_SECTION_END   = 2'd3;

   // Record kinds; KIND_DONE marks the end of a summary walk.
   localparam logic [1:0] KIND_AVG  = 2'd0;
   localparam logic [1:0] KIND_MIN  = 2'd1;
   localparam logic [1:0] KIND_MAX  = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILING_ON = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_MASK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_AVERAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_MINIMUM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_MAXIMUM = 3'd4;

   typedef struct packed {
      logic [1:0]      op;
      logic [3:0]      section_id;
      logic [TS_W-1:0] timestamp_ms;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         stat_kind;
      logic [SLOT_W-1:0]  slot;
      logic [TOTAL_W-1:0] value;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] tot;
      logic [TS_W-1:0]    lo;
      logic [TS_W-1:0]    hi;
   } agg_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sum_init;
      logic advance;
      logic rd_slot;
      logic load_out;
      logic sum_clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sum_due;
      logic seq_done;
      logic skip;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/slm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  slm_pkg::dp_status_type sts,
   output slm_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_EXEC     = 2'd1;
   localparam logic [1:0] ST_SUM_READ = 2'd2;
   localparam logic [1:0] ST_SUM_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.sum_due) begin
               cmd.sum_init = 1'b1;
               state_in     = ST_SUM_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM_READ: begin
            if (sts.seq_done) begin
               cmd.sum_clear = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.skip) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.rd_slot = 1'b1;
               state_in    = ST_SUM_EMIT;
            end
         end
         ST_SUM_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.advance  = 1'b1;
               state_in     = ST_SUM_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/slm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  slm_pkg::req_payload_type             req_payload,
   input  logic                                 csr_we,
   input  logic [slm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [slm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output slm_pkg::rsp_payload_type             rsp_payload,
   input  slm_pkg::ctrl_cmd_type                cmd,
   output slm_pkg::dp_status_type               sts
);

   function automatic slm_pkg::agg_type accumulate(input slm_pkg::agg_type a,
                                                   input logic [slm_pkg::TS_W-1:0] e);
      logic [slm_pkg::TOTAL_W:0] sum;
      slm_pkg::agg_type          r;
      sum   = {1'b0, a.tot} + {{(slm_pkg::TOTAL_W - slm_pkg::TS_W + 1){1'b0}}, e};
      r.tot = sum[slm_pkg::TOTAL_W] ? '1 : sum[slm_pkg::TOTAL_W-1:0];
      r.lo  = ((a.lo == '0) || (e < a.lo)) ? e : a.lo;
      r.hi  = (e > a.hi) ? e : a.hi;
      return r;
   endfunction

   // Section store: one read port with a registered output, one write port.
   slm_pkg::agg_type          agg_mem   [slm_pkg::SECTIONS];
   logic [slm_pkg::TS_W-1:0]  start_mem [slm_pkg::SECTIONS];

   logic                                profiling_on_ff, profiling_on_in;
   logic [15:0]                         section_mask_ff, section_mask_in;
   logic [2:0]                          show_ff, show_in;
   slm_pkg::req_payload_type            item_ff, item_in;
   logic [slm_pkg::SECTIONS-1:0]        started_ff, started_in;
   logic [slm_pkg::SECTIONS-1:0]        agg_valid_ff, agg_valid_in;
   logic [slm_pkg::TS_W-1:0]            frame_start_ff, frame_start_in;
   logic                                frame_started_ff, frame_started_in;
   slm_pkg::agg_type                    frame_agg_ff, frame_agg_in;
   logic [slm_pkg::FRAMES_W-1:0]        frames_seen_ff, frames_seen_in;
   logic [1:0]                          kind_ff, kind_in;
   logic [slm_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   slm_pkg::agg_type                    rd_agg_ff;
   logic [slm_pkg::TS_W-1:0]            rd_start_ff;
   logic                                rd_valid_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   slm_pkg::rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic [slm_pkg::SEC_AW-1:0]          rd_addr;
   logic                                rd_en;
   logic [slm_pkg::SEC_AW-1:0]          item_idx;
   logic                                item_sec_on;
   logic [slm_pkg::TS_W-1:0]            sec_elapsed;
   logic [slm_pkg::TS_W-1:0]            frame_elapsed;
   slm_pkg::agg_type                    sec_base;
   slm_pkg::agg_type                    sec_new;
   logic [slm_pkg::FRAMES_W-1:0]        frames_next;
   logic                                do_frame_end;
   logic                                do_sec_begin;
   logic                                do_sec_end;
   logic                                clear_all;
   logic [3:0]                          show_vec;
   logic                                frame_slot;
   slm_pkg::agg_type                    sum_agg;
   logic [slm_pkg::TOTAL_W+slm_pkg::FRAC_W-1:0] scaled_total;
   logic [slm_pkg::TOTAL_W+slm_pkg::FRAC_W-1:0] avg_full;
   logic [slm_pkg::TOTAL_W-1:0]         stat_value;
   logic [3:0]                          later_shown;

   assign rd_en   = cmd.capture || cmd.rd_slot;
   assign rd_addr = cmd.rd_slot ? slot_ff[slm_pkg::SEC_AW-1:0]
                                : req_payload.section_id[slm_pkg::SEC_AW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_agg_ff   <= agg_mem[rd_addr];
         rd_start_ff <= start_mem[rd_addr];
         rd_valid_ff <= agg_valid_ff[rd_addr];
      end
      if (do_sec_begin) begin
         start_mem[item_idx] <= item_ff.timestamp_ms;
      end
      if (do_sec_end) begin
         agg_mem[item_idx] <= sec_new;
      end
   end

   // Event decode for the item held in item_ff.
   assign item_idx    = item_ff.section_id[slm_pkg::SEC_AW-1:0];
   assign item_sec_on = ({1'b0, item_ff.section_id} < 5'(slm_pkg::SECTIONS))
                        && section_mask_ff[item_ff.section_id];
   assign sec_elapsed   = item_ff.timestamp_ms - rd_start_ff;
   assign frame_elapsed = item_ff.timestamp_ms - frame_start_ff;
   assign sec_base      = rd_valid_ff ? rd_agg_ff : '0;
   assign sec_new       = accumulate(sec_base, sec_elapsed);
   assign frames_next   = frames_seen_ff + 1'b1;

   assign do_frame_end = cmd.exec && profiling_on_ff && (item_ff.op == slm_pkg::OP_FRAME_END)
                         && frame_started_ff;
   assign do_sec_begin = cmd.exec && profiling_on_ff
                         && (item_ff.op == slm_pkg::OP_SECTION_BEGIN) && item_sec_on;
   assign do_sec_end   = cmd.exec && profiling_on_ff && (item_ff.op == slm_pkg::OP_SECTION_END)
                         && item_sec_on && started_ff[item_idx];

   assign clear_all = cmd.sum_clear
                      || (csr_we && (csr_index == slm_pkg::CSR_PROFILING_ON) && csr_wdata[0]);

   // Summary walk over kinds and slots.
   assign show_vec    = {1'b0, show_ff};
   assign frame_slot  = (slot_ff == slm_pkg::FRAME_SLOT);
   assign sum_agg     = frame_slot ? frame_agg_ff : (rd_valid_ff ? rd_agg_ff : '0);
   assign scaled_total = {sum_agg.tot, {slm_pkg::FRAC_W{1'b0}}};
   assign avg_full     = scaled_total / slm_pkg::FRAMES_PER_SUMMARY;
   assign later_shown  = show_vec >> (3'(kind_ff) + 3'd1);

   always_comb begin
      unique case (kind_ff)
         slm_pkg::KIND_AVG: stat_value = avg_full[slm_pkg::TOTAL_W-1:0];
         slm_pkg::KIND_MIN: stat_value = {sum_agg.lo, {slm_pkg::FRAC_W{1'b0}}};
         default:           stat_value = {sum_agg.hi, {slm_pkg::FRAC_W{1'b0}}};
      endcase
   end

   assign sts.sum_due  = do_frame_end
                         && (frames_next >= slm_pkg::FRAMES_W'(slm_pkg::FRAMES_PER_SUMMARY));
   assign sts.seq_done = (kind_ff == slm_pkg::KIND_DONE);
   assign sts.skip     = !show_vec[kind_ff] || (!frame_slot && !section_mask_ff[slot_ff[3:0]]);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      profiling_on_in  = profiling_on_ff;
      section_mask_in  = section_mask_ff;
      show_in          = show_ff;
      item_in          = item_ff;
      started_in       = started_ff;
      agg_valid_in     = agg_valid_ff;
      frame_start_in   = frame_start_ff;
      frame_started_in = frame_started_ff;
      frame_agg_in     = frame_agg_ff;
      frames_seen_in   = frames_seen_ff;
      kind_in          = kind_ff;
      slot_in          = slot_ff;

      if (csr_we) begin
         unique case (csr_index)
            slm_pkg::CSR_PROFILING_ON: profiling_on_in = csr_wdata[0];
            slm_pkg::CSR_SECTION_MASK: section_mask_in = csr_wdata;
            slm_pkg::CSR_SHOW_AVERAGE: show_in[0]      = csr_wdata[0];
            slm_pkg::CSR_SHOW_MINIMUM: show_in[1]      = csr_wdata[0];
            slm_pkg::CSR_SHOW_MAXIMUM: show_in[2]      = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         item_in = req_payload;
      end

      if (cmd.exec && profiling_on_ff && (item_ff.op == slm_pkg::OP_FRAME_BEGIN)) begin
         frame_start_in   = item_ff.timestamp_ms;
         frame_started_in = 1'b1;
      end
      if (do_frame_end) begin
         frame_agg_in     = accumulate(frame_agg_ff, frame_elapsed);
         frames_seen_in   = frames_next;
         frame_started_in = 1'b0;
      end
      if (do_sec_begin) begin
         started_in[item_idx] = 1'b1;
      end
      if (do_sec_end) begin
         started_in[item_idx]   = 1'b0;
         agg_valid_in[item_idx] = 1'b1;
      end

      if (cmd.sum_init) begin
         kind_in = slm_pkg::KIND_AVG;
         slot_in = '0;
      end else if (cmd.advance) begin
         if (frame_slot || !show_vec[kind_ff]) begin
            kind_in = kind_ff + 2'd1;
            slot_in = '0;
         end else if (slot_ff + 1'b1 == slm_pkg::SLOT_W'(slm_pkg::SECTIONS)) begin
            slot_in = slm_pkg::FRAME_SLOT;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end

      // Start times and frame_started survive a clear; the started bits do not.
      if (clear_all) begin
         started_in     = '0;
         agg_valid_in   = '0;
         frame_agg_in   = '0;
         frames_seen_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in   = cmd.load_out || (rsp_valid_ff && rsp_stall);
      rsp_payload_in = rsp_payload_ff;
      if (cmd.load_out) begin
         rsp_payload_in.stat_kind = kind_ff;
         rsp_payload_in.slot      = slot_ff;
         rsp_payload_in.value     = stat_value;
         rsp_payload_in.last      = frame_slot && (later_shown == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profiling_on_ff  <= 1'b0;
         section_mask_ff  <= '1;
         show_ff          <= '1;
         started_ff       <= '0;
         agg_valid_ff     <= '0;
         frame_start_ff   <= '0;
         frame_started_ff <= 1'b0;
         frame_agg_ff     <= '0;
         frames_seen_ff   <= '0;
         kind_ff          <= slm_pkg::KIND_DONE;
         slot_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         profiling_on_ff  <= profiling_on_in;
         section_mask_ff  <= section_mask_in;
         show_ff          <= show_in;
         started_ff       <= started_in;
         agg_valid_ff     <= agg_valid_in;
         frame_start_ff   <= frame_start_in;
         frame_started_ff <= frame_started_in;
         frame_agg_ff     <= frame_agg_in;
         frames_seen_ff   <= frames_seen_in;
         kind_ff          <= kind_in;
         slot_ff          <= slot_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ src/section_latency_monitor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Section latency monitor.
// Events (frame begin/end, section begin/end, each with a millisecond timestamp)
// arrive on the req_ channel; a transaction is taken when req_valid is high and
// req_stall is low. Summary records leave on the rsp_ channel under the same
// rule with rsp_stall driven by the receiver. Registers are written on the csr_
// channel, which is always ready; write only while the block is idle.
// Each event is captured, with a read of the section store, and then the store
// and the frame aggregates are updated; the next event is not taken until the
// update is done. The single read port of the section store sets the summary
// pace: a shown record is read and then loaded into the output register, a
// masked slot or hidden group takes only a read step, and a last step clears the
// aggregates; a full summary has 51 records. No event is taken during a summary.
// A record waits in the output register while rsp_stall is high; the summary
// walk pauses behind it, but an event can be taken while it waits otherwise.
// Reset (synchronous) clears all aggregates and start flags, turns profiling
// off and restores the mask and show flags to all ones.
module section_latency_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  slm_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output slm_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   slm_pkg::ctrl_cmd_type  cmd;
   slm_pkg::dp_status_type sts;
   logic                   csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   slm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

@@ src/slm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "section_latency_monitor_macros.svh"

module slm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input slm_pkg::rsp_payload_type rsp_payload
);

   `SLM_ASSERT_NEXT(a_rsp_valid_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")
   `SLM_ASSERT_NEXT(a_rsp_payload_held, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "rsp_payload changed while stalled")
   `SLM_ASSERT_IMPL(a_last_on_frame, clock, reset, rsp_valid && rsp_payload.last, rsp_payload.slot == slm_pkg::FRAME_SLOT, "last flag on a section record")
   `SLM_ASSERT_IMPL(a_kind_legal, clock, reset, rsp_valid, (rsp_payload.stat_kind != slm_pkg::KIND_DONE) && (rsp_payload.slot <= slm_pkg::FRAME_SLOT), "record kind or slot out of range")

endmodule

bind section_latency_monitor slm_checker u_slm_checker (.*);

`default_nettype wire
